[sv/tct_pkg.sv]
// ----------------------------------------------------------------------------
// tct_pkg
// Types, codes and decode functions shared by the TCP connection tracker.
// ----------------------------------------------------------------------------
package tct_pkg;

  // Connection state codes.
  localparam logic [3:0] ST_PENDING    = 4'd0;
  localparam logic [3:0] ST_SYN_SENT   = 4'd1;
  localparam logic [3:0] ST_SYN_RCVD   = 4'd2;
  localparam logic [3:0] ST_ESTAB      = 4'd3;
  localparam logic [3:0] ST_FINWAIT1   = 4'd4;
  localparam logic [3:0] ST_FINWAIT2   = 4'd5;
  localparam logic [3:0] ST_CLOSE_WAIT = 4'd6;
  localparam logic [3:0] ST_CLOSING    = 4'd7;
  localparam logic [3:0] ST_TIME_WAIT  = 4'd8;
  localparam logic [3:0] ST_CLOSED     = 4'd9;

  // Bit positions in the flag byte.
  localparam int unsigned B_RFIN     = 0;
  localparam int unsigned B_RFIN_ACK = 1;
  localparam int unsigned B_RSYN     = 2;
  localparam int unsigned B_RSYN_ACK = 3;
  localparam int unsigned B_LFIN     = 4;
  localparam int unsigned B_LFIN_ACK = 5;
  localparam int unsigned B_LSYN     = 6;
  localparam int unsigned B_LSYN_ACK = 7;

  localparam logic [7:0]  CLOSED_CODE = 8'h01;
  localparam logic [15:0] MAX_TIMEOUT = 16'd43200;

  localparam int unsigned IN_BITS  = 72;
  localparam int unsigned OUT_BITS = 32;

  typedef struct packed {
    logic        func;
    logic        flag_rst;
    logic        flag_syn;
    logic        flag_fin;
    logic        flag_ack;
    logic [31:0] tcp_seq;
    logic [31:0] tcp_ack_number;
  } tct_seg_t;

  typedef struct packed {
    logic [7:0]  flags;
    logic [31:0] local_syn_number;
    logic [31:0] local_fin_number;
    logic [31:0] remote_syn_number;
    logic [31:0] remote_fin_number;
  } tct_ctx_t;

  typedef struct packed {
    logic [3:0]  conn_state;
    logic [7:0]  flag_bits;
    logic [15:0] idle_timeout;
    logic        state_changed;
  } tct_res_t;

  // Maps a flag byte to a connection state. The remote nibble falls into one
  // of three legal groups; the local nibble then picks the state.
  function automatic logic [3:0] state_of_flags(input logic [7:0] f);
    logic [1:0] lc;
    logic [3:0] st;
    case (f[3:0])
      4'h0, 4'h4, 4'h5: lc = 2'd0;
      4'hC, 4'hD:       lc = 2'd1;
      4'hF:             lc = 2'd2;
      default:          lc = 2'd3;
    endcase
    st = ST_CLOSED;
    if (lc != 2'd3) begin
      case (f[7:4])
        4'h0: st = ST_PENDING;
        4'h4: st = (lc == 2'd0) ? ST_SYN_SENT : ST_SYN_RCVD;
        4'h5, 4'hD: begin
          case (lc)
            2'd0:    st = ST_SYN_SENT;
            2'd1:    st = ST_FINWAIT1;
            default: st = ST_CLOSING;
          endcase
        end
        4'hC: begin
          case (lc)
            2'd0:    st = ST_SYN_SENT;
            2'd1:    st = ST_ESTAB;
            default: st = ST_CLOSE_WAIT;
          endcase
        end
        4'hF: begin
          case (lc)
            2'd0:    st = ST_SYN_SENT;
            2'd1:    st = ST_FINWAIT2;
            default: st = ST_TIME_WAIT;
          endcase
        end
        default: st = ST_CLOSED;
      endcase
    end
    return st;
  endfunction

  function automatic logic [15:0] timeout_of_state(input logic [3:0] st);
    logic [15:0] t;
    case (st)
      ST_PENDING:    t = 16'd6;
      ST_SYN_SENT:   t = 16'd12;
      ST_SYN_RCVD:   t = 16'd6;
      ST_ESTAB:      t = MAX_TIMEOUT;
      ST_FINWAIT1:   t = 16'd12;
      ST_FINWAIT2:   t = 16'd12;
      ST_CLOSE_WAIT: t = 16'd12;
      ST_CLOSING:    t = 16'd12;
      ST_TIME_WAIT:  t = 16'd2;
      default:       t = 16'd1;
    endcase
    return t;
  endfunction

endpackage

[sv/tct_update.sv]
// ----------------------------------------------------------------------------
// tct_update
// Combinational step: applies one segment header to the connection context
// and produces the next context and the result fields.
// ----------------------------------------------------------------------------
module tct_update (
  input  tct_pkg::tct_seg_t seg,
  input  tct_pkg::tct_ctx_t ctx,
  output tct_pkg::tct_ctx_t ctx_next,
  output tct_pkg::tct_res_t res
);
  import tct_pkg::*;

  logic [31:0] ack_syn_diff;
  logic [31:0] ack_fin_diff;
  logic        syn_acked;
  logic        fin_acked;
  logic [3:0]  st;

  // The ACK always refers to the other side's SYN and FIN. "After" means the
  // difference modulo 2^32 is nonzero with the top bit clear.
  always_comb begin
    if (seg.func) begin
      ack_syn_diff = seg.tcp_ack_number - ctx.remote_syn_number;
      ack_fin_diff = seg.tcp_ack_number - ctx.remote_fin_number;
    end else begin
      ack_syn_diff = seg.tcp_ack_number - ctx.local_syn_number;
      ack_fin_diff = seg.tcp_ack_number - ctx.local_fin_number;
    end
  end

  assign syn_acked = (ack_syn_diff != 32'd0) && !ack_syn_diff[31];
  assign fin_acked = (ack_fin_diff != 32'd0) && !ack_fin_diff[31];

  always_comb begin
    ctx_next = ctx;
    if (seg.flag_rst) begin
      ctx_next.flags = CLOSED_CODE;
    end else if (seg.func) begin
      if (seg.flag_syn) begin
        ctx_next.flags[B_LSYN]    = 1'b1;
        ctx_next.local_syn_number = seg.tcp_seq;
      end
      if (seg.flag_fin) begin
        ctx_next.flags[B_LFIN]    = 1'b1;
        ctx_next.local_fin_number = seg.tcp_seq;
      end
      if (seg.flag_ack) begin
        if (ctx.flags[B_RSYN] && syn_acked) ctx_next.flags[B_RSYN_ACK] = 1'b1;
        if (ctx.flags[B_RFIN] && fin_acked) ctx_next.flags[B_RFIN_ACK] = 1'b1;
      end
    end else begin
      if (seg.flag_syn) begin
        ctx_next.flags[B_RSYN]     = 1'b1;
        ctx_next.remote_syn_number = seg.tcp_seq;
      end
      if (seg.flag_fin) begin
        ctx_next.flags[B_RFIN]     = 1'b1;
        ctx_next.remote_fin_number = seg.tcp_seq;
      end
      if (seg.flag_ack) begin
        if (ctx.flags[B_LSYN] && syn_acked) ctx_next.flags[B_LSYN_ACK] = 1'b1;
        if (ctx.flags[B_LFIN] && fin_acked) ctx_next.flags[B_LFIN_ACK] = 1'b1;
      end
    end
  end

  assign st = state_of_flags(ctx_next.flags);

  always_comb begin
    res.conn_state    = st;
    res.flag_bits     = ctx_next.flags;
    res.idle_timeout  = timeout_of_state(st);
    res.state_changed = (ctx_next.flags != ctx.flags);
  end

endmodule

[sv/tcp_connection_tracker.sv]
// ----------------------------------------------------------------------------
// tcp_connection_tracker
// Follows one TCP connection from the segment headers seen in both directions.
// ----------------------------------------------------------------------------
// The tracker takes one segment header per clock and returns one result per
// header, in order. Each header passes through the input register and then
// the result register, which it enters once that register is free or being
// read. The flag update, the two modulo-2^32 acknowledgment compares and the
// state decode run combinationally between the two registers. The connection
// context is loaded at the same edge as the result, so back-to-back headers
// see each other's effect. Throughput is one transfer per cycle; a stall on
// the output holds the input register and drops s_tready only once both
// registers are full.
module tcp_connection_tracker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [0] func, [1] flag_rst, [2] flag_syn, [3] flag_fin, [4] flag_ack,
  // [36:5] tcp_seq, [68:37] tcp_ack_number, [71:69] zero
  input  logic [tct_pkg::IN_BITS-1:0]   s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [3:0] conn_state, [11:4] flag_bits, [27:12] idle_timeout,
  // [28] state_changed, [31:29] zero
  output logic [tct_pkg::OUT_BITS-1:0]  m_tdata
);
  import tct_pkg::*;

  logic     in_valid;
  tct_seg_t seg;
  logic     out_valid;
  tct_res_t res_q;
  tct_ctx_t ctx;
  tct_ctx_t ctx_next;
  tct_res_t res;
  logic     advance;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  tct_update u_update (
    .seg      (seg),
    .ctx      (ctx),
    .ctx_next (ctx_next),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      ctx       <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
        ctx       <= ctx_next;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      seg.func           <= s_tdata[0];
      seg.flag_rst       <= s_tdata[1];
      seg.flag_syn       <= s_tdata[2];
      seg.flag_fin       <= s_tdata[3];
      seg.flag_ack       <= s_tdata[4];
      seg.tcp_seq        <= s_tdata[36:5];
      seg.tcp_ack_number <= s_tdata[68:37];
    end
    if (advance) begin
      res_q <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, res_q.state_changed, res_q.idle_timeout,
                     res_q.flag_bits, res_q.conn_state};

endmodule

[sv/tct_checker.sv]
// ----------------------------------------------------------------------------
// tct_checker
// Port-level checks on the tracker's handshakes and result fields.
// ----------------------------------------------------------------------------
module tct_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [tct_pkg::OUT_BITS-1:0]  m_tdata
);
  import tct_pkg::*;

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // A result with the closed flag code always decodes as the closed state with the shortest timeout.
  a_closed: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[11:4] == CLOSED_CODE) |->
      (m_tdata[3:0] == ST_CLOSED) && (m_tdata[27:12] == 16'd1))
    else $error("closed code decoded wrongly");

  // Only an established connection gets the long timeout.
  a_estab: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[3:0] == ST_ESTAB) == (m_tdata[27:12] == MAX_TIMEOUT)))
    else $error("timeout does not match state");

  // With no result pending and no transfer in the previous cycle the pipeline
  // is empty, so a transfer now cannot produce a result in the next cycle.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid && s_tvalid && s_tready && !$past(s_tvalid && s_tready) |=> !m_tvalid)
    else $error("result appeared too early");

  // Padding bits of the result stay zero.
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[31:29] == 3'b000))
    else $error("result padding not zero");

endmodule

bind tcp_connection_tracker tct_checker u_tct_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

[tb/tcp_tracker_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tcp_tracker_checker
// Watches both stream channels of the TCP connection tracker. It keeps its
// own copy of the connection flags and the four SYN/FIN sequence numbers.
// It predicts the result of every accepted header and compares each result
// transfer with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module tcp_tracker_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  input  logic                         s_tready,
  input  logic [tct_pkg::IN_BITS-1:0]  s_tdata,
  input  logic                         m_tvalid,
  input  logic                         m_tready,
  input  logic [tct_pkg::OUT_BITS-1:0] m_tdata,
  output int                           mismatch_count,
  output int                           results_owed
);
  import tct_pkg::*;

  typedef struct packed {
    logic [3:0]  conn_state;
    logic [7:0]  flag_bits;
    logic [15:0] idle_timeout;
    logic        state_changed;
  } tracker_result_t;

  tracker_result_t pending_results[$];
  tracker_result_t want;
  tracker_result_t got;

  logic [7:0]  conn_flags;
  logic [31:0] local_syn_seq;
  logic [31:0] local_fin_seq;
  logic [31:0] peer_syn_seq;
  logic [31:0] peer_fin_seq;
  int          reports_shown;

  // An ack covers a sequence number when it lies strictly ahead of it within
  // half the 32-bit sequence space.
  function automatic bit acks_beyond(input logic [31:0] seq, input logic [31:0] an);
    logic [31:0] span;
    span = an - seq;
    return (span != 32'd0) && !span[31];
  endfunction

  function automatic logic [3:0] conn_state_of(input logic [7:0] f);
    int peer_col;
    case (f[3:0])
      4'h0, 4'h4, 4'h5: peer_col = 0;   // peer SYN not yet acknowledged
      4'hC, 4'hD:       peer_col = 1;   // peer SYN acknowledged
      4'hF:             peer_col = 2;   // peer SYN and FIN acknowledged
      default:          return ST_CLOSED;
    endcase
    case (f[7:4])
      4'h0:       return ST_PENDING;
      4'h4:       return (peer_col == 0) ? ST_SYN_SENT : ST_SYN_RCVD;
      4'h5, 4'hD: return (peer_col == 0) ? ST_SYN_SENT :
                         (peer_col == 1) ? ST_FINWAIT1 : ST_CLOSING;
      4'hC:       return (peer_col == 0) ? ST_SYN_SENT :
                         (peer_col == 1) ? ST_ESTAB : ST_CLOSE_WAIT;
      4'hF:       return (peer_col == 0) ? ST_SYN_SENT :
                         (peer_col == 1) ? ST_FINWAIT2 : ST_TIME_WAIT;
      default:    return ST_CLOSED;
    endcase
  endfunction

  function automatic logic [15:0] timeout_for(input logic [3:0] st);
    case (st)
      ST_PENDING, ST_SYN_RCVD:                         return 16'd6;
      ST_SYN_SENT, ST_FINWAIT1, ST_FINWAIT2,
      ST_CLOSE_WAIT, ST_CLOSING:                       return 16'd12;
      ST_ESTAB:                                        return MAX_TIMEOUT;
      ST_TIME_WAIT:                                    return 16'd2;
      default:                                         return 16'd1;
    endcase
  endfunction

  task automatic track_segment(input logic [IN_BITS-1:0] seg, output tracker_result_t res);
    logic        from_local;
    logic        abort;
    logic        syn;
    logic        fin;
    logic        ack;
    logic [31:0] seq;
    logic [31:0] an;
    logic [7:0]  f;
    from_local = seg[0];
    abort      = seg[1];
    syn        = seg[2];
    fin        = seg[3];
    ack        = seg[4];
    seq        = seg[36:5];
    an         = seg[68:37];
    f          = conn_flags;
    if (abort) begin
      f = CLOSED_CODE;
    end else if (from_local) begin
      if (syn) begin
        f[B_LSYN] = 1'b1;
        local_syn_seq = seq;
      end
      if (fin) begin
        f[B_LFIN] = 1'b1;
        local_fin_seq = seq;
      end
      if (ack) begin
        if (f[B_RSYN] && !f[B_RSYN_ACK] && acks_beyond(peer_syn_seq, an))
          f[B_RSYN_ACK] = 1'b1;
        if (f[B_RFIN] && !f[B_RFIN_ACK] && acks_beyond(peer_fin_seq, an))
          f[B_RFIN_ACK] = 1'b1;
      end
    end else begin
      if (syn) begin
        f[B_RSYN] = 1'b1;
        peer_syn_seq = seq;
      end
      if (fin) begin
        f[B_RFIN] = 1'b1;
        peer_fin_seq = seq;
      end
      if (ack) begin
        if (f[B_LSYN] && !f[B_LSYN_ACK] && acks_beyond(local_syn_seq, an))
          f[B_LSYN_ACK] = 1'b1;
        if (f[B_LFIN] && !f[B_LFIN_ACK] && acks_beyond(local_fin_seq, an))
          f[B_LFIN_ACK] = 1'b1;
      end
    end
    res.conn_state    = conn_state_of(f);
    res.flag_bits     = f;
    res.idle_timeout  = timeout_for(res.conn_state);
    res.state_changed = (f != conn_flags);
    conn_flags = f;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      conn_flags    = 8'h00;
      local_syn_seq = 32'd0;
      local_fin_seq = 32'd0;
      peer_syn_seq  = 32'd0;
      peer_fin_seq  = 32'd0;
      pending_results.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        track_segment(s_tdata, want);
        pending_results.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        got.conn_state    = m_tdata[3:0];
        got.flag_bits     = m_tdata[11:4];
        got.idle_timeout  = m_tdata[27:12];
        got.state_changed = m_tdata[28];
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (reports_shown < 100) begin
            reports_shown++;
            $display({"%0t: result transfer with nothing expected: ",
                      "state %0d flags %h timeout %0d changed %0b"},
                     $time, got.conn_state, got.flag_bits, got.idle_timeout,
                     got.state_changed);
          end
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (reports_shown < 100) begin
              reports_shown++;
              $display({"%0t: mismatch: expected state %0d flags %h timeout %0d ",
                        "changed %0b, got state %0d flags %h timeout %0d changed %0b"},
                       $time, want.conn_state, want.flag_bits, want.idle_timeout,
                       want.state_changed, got.conn_state, got.flag_bits,
                       got.idle_timeout, got.state_changed);
            end
          end
        end
      end
    end
    results_owed = pending_results.size();
  end

endmodule

[tb/tcp_connection_tracker_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tcp_connection_tracker_test
// Drives segment headers into the TCP connection tracker and gives the verdict.
// A short directed walk covers an active open and close, resets, sequence wrap
// and the half-space ack boundary; random handshakes, data and teardowns mixed
// with malformed headers follow, under random stalls on both channels.
// ----------------------------------------------------------------------------
module tcp_connection_tracker_test;
  import tct_pkg::*;

  localparam bit FROM_PEER   = 1'b0;
  localparam bit FROM_LOCAL  = 1'b1;
  localparam int HOLD_CYCLES = 60;
  localparam int ITEM_TARGET = 870;
  localparam int CYCLE_LIMIT = 500000;

  logic                clk = 1'b0;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [IN_BITS-1:0]  s_tdata;
  logic                m_tvalid;
  logic                m_tready;
  logic [OUT_BITS-1:0] m_tdata;

  int          mismatch_count;
  int          results_owed;
  int          segments_sent;
  int          cycle_count;
  bit          hold_request;
  bit          steady;
  bit          burst;
  logic [31:0] recent_seq;

  always #4 clk = ~clk;

  tcp_connection_tracker DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  tcp_tracker_checker tracker_check (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic int stall_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // Offsets that land on or around the edges of the ack test.
  function automatic logic [31:0] near_offset();
    case ($urandom_range(0, 6))
      0:       return 32'h0000_0000;
      1:       return 32'h0000_0001;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h7FFF_FFFF;
      4:       return 32'h8000_0000;
      5:       return 32'h8000_0001;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_isn();
    case ($urandom_range(0, 7))
      0, 1:    return 32'hFFFF_FFFF - $urandom_range(0, 3);
      2:       return 32'h7FFF_FFFF - $urandom_range(0, 2);
      default: return $urandom;
    endcase
  endfunction

  // Called at a falling edge; returns at a falling edge after the transfer.
  task automatic send_seg(input bit from_local, input bit abort, input bit syn,
                          input bit fin, input bit ack, input logic [31:0] seq,
                          input logic [31:0] an);
    int gap;
    s_tdata  = {3'b000, an, seq, ack, fin, syn, abort, from_local};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    segments_sent++;
    recent_seq = seq;
    @(negedge clk);
    s_tvalid = 1'b0;
    gap = (steady || burst) ? 0 : sender_gap();
    repeat (gap) @(negedge clk);
  endtask

  task automatic wait_drained();
    while (results_owed != 0) @(negedge clk);
  endtask

  task automatic send_noise();
    int          count;
    int          k;
    logic [31:0] seq;
    count = $urandom_range(1, 6);
    for (k = 0; k < count; k++) begin
      seq = $urandom_range(0, 1) ? $urandom : recent_seq + near_offset();
      send_seg($urandom_range(0, 1), $urandom_range(0, 7) == 0, $urandom_range(0, 1),
               $urandom_range(0, 1), $urandom_range(0, 1), seq,
               recent_seq + near_offset());
    end
  endtask

  // One connection: open, some data, close, with the occasional fault.
  task automatic run_session();
    logic [31:0] nxt [2];
    bit          opener;
    bit          closer;
    bit          side;
    int          n_data;
    int          k;
    nxt[0] = pick_isn();
    nxt[1] = pick_isn();
    opener = $urandom_range(0, 1);
    // Unless skipped at random, a reset segment first clears whatever the previous connection left.
    if ($urandom_range(0, 4) != 0)
      send_seg($urandom_range(0, 1), 1'b1, 1'b0, 1'b0, 1'b0, $urandom, $urandom);
    send_seg(opener, 1'b0, 1'b1, 1'b0, 1'b0, nxt[opener], $urandom);
    nxt[opener]++;
    if ($urandom_range(0, 5) == 0) begin
      // Simultaneous open: the peer's SYN carries no ack.
      send_seg(!opener, 1'b0, 1'b1, 1'b0, 1'b0, nxt[!opener], $urandom);
      nxt[!opener]++;
      send_seg(!opener, 1'b0, 1'b0, 1'b0, 1'b1, nxt[!opener], nxt[opener]);
    end else begin
      send_seg(!opener, 1'b0, 1'b1, 1'b0, 1'b1, nxt[!opener], nxt[opener]);
      nxt[!opener]++;
    end
    if ($urandom_range(0, 9) == 0)
      send_seg(opener, 1'b0, 1'b1, 1'b0, 1'b0, nxt[opener] - 1, $urandom);
    send_seg(opener, 1'b0, 1'b0, 1'b0, 1'b1, nxt[opener], nxt[!opener]);

    n_data = $urandom_range(0, 4);
    for (k = 0; k < n_data; k++) begin
      side = $urandom_range(0, 1);
      if ($urandom_range(0, 11) == 0) begin
        send_seg(side, 1'b1, $urandom_range(0, 1), $urandom_range(0, 1),
                 $urandom_range(0, 1), nxt[side], nxt[!side]);
        return;
      end
      send_seg(side, 1'b0, 1'b0, 1'b0, 1'b1, nxt[side],
               ($urandom_range(0, 7) == 0) ? nxt[!side] - $urandom_range(0, 3)
                                           : nxt[!side]);
      nxt[side] += $urandom_range(0, 1460);
    end

    closer = $urandom_range(0, 1);
    send_seg(closer, 1'b0, 1'b0, 1'b1, 1'b1, nxt[closer], nxt[!closer]);
    nxt[closer]++;
    if ($urandom_range(0, 3) == 0) begin
      send_seg(!closer, 1'b0, 1'b0, 1'b1, 1'b1, nxt[!closer], nxt[closer]);
      nxt[!closer]++;
    end else begin
      send_seg(!closer, 1'b0, 1'b0, 1'b0, 1'b1, nxt[!closer], nxt[closer]);
      if ($urandom_range(0, 1)) begin
        send_seg(!closer, 1'b0, 1'b0, 1'b0, 1'b1, nxt[!closer], nxt[closer]);
        nxt[!closer] += $urandom_range(1, 1460);
      end
      send_seg(!closer, 1'b0, 1'b0, 1'b1, 1'b1, nxt[!closer], nxt[closer]);
      nxt[!closer]++;
    end
    send_seg(closer, 1'b0, 1'b0, 1'b0, 1'b1, nxt[closer], nxt[!closer]);
    if ($urandom_range(0, 5) == 0)
      send_seg(closer, 1'b0, 1'b0, 1'b0, 1'b1, nxt[closer], nxt[!closer]);
  endtask

  task automatic random_traffic(input int until_count);
    while (segments_sent < until_count) begin
      if ($urandom_range(0, 9) < 8) run_session();
      else send_noise();
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_request) begin
        m_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end else if (!steady && $urandom_range(0, 3) == 0) begin
        m_tready = 1'b0;
        repeat (stall_length()) @(negedge clk);
      end
      m_tready = 1'b1;
      @(negedge clk);
    end
  end

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed walk through the states and the ack boundaries.
    send_seg(FROM_PEER,  1'b0, 1'b0, 1'b0, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF);
    send_seg(FROM_LOCAL, 1'b0, 1'b1, 1'b0, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_seg(FROM_PEER,  1'b0, 1'b0, 1'b0, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF);
    send_seg(FROM_PEER,  1'b0, 1'b1, 1'b0, 1'b1, 32'h0000_0000, 32'h7FFF_FFFF);
    send_seg(FROM_PEER,  1'b0, 1'b0, 1'b0, 1'b1, 32'h0000_0001, 32'h7FFF_FFFE);
    send_seg(FROM_LOCAL, 1'b0, 1'b0, 1'b0, 1'b1, 32'h0000_0000, 32'h0000_0000);
    send_seg(FROM_LOCAL, 1'b0, 1'b0, 1'b0, 1'b1, 32'h0000_0000, 32'h0000_0001);
    send_seg(FROM_LOCAL, 1'b0, 1'b0, 1'b1, 1'b1, 32'h8000_0000, 32'h0000_0001);
    send_seg(FROM_PEER,  1'b0, 1'b0, 1'b0, 1'b1, 32'h0000_0001, 32'h8000_0000);
    send_seg(FROM_PEER,  1'b0, 1'b0, 1'b1, 1'b0, 32'hFFFF_FFFF, 32'h0000_0000);
    send_seg(FROM_PEER,  1'b0, 1'b0, 1'b0, 1'b1, 32'h0000_0000, 32'h8000_0001);
    send_seg(FROM_LOCAL, 1'b0, 1'b0, 1'b0, 1'b1, 32'h8000_0001, 32'h0000_0000);
    send_seg(FROM_LOCAL, 1'b0, 1'b0, 1'b0, 1'b1, 32'h8000_0001, 32'h0000_0000);
    send_seg(FROM_PEER,  1'b1, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_seg(FROM_LOCAL, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0000_0000, 32'h0000_0000);
    // The first header below makes a flag byte that no sound exchange produces; it must decode as closed.
    send_seg(FROM_LOCAL, 1'b0, 1'b1, 1'b1, 1'b1, 32'h1234_5678, 32'h0000_0000);
    send_seg(FROM_PEER,  1'b0, 1'b1, 1'b1, 1'b1, 32'h0000_0000, 32'h1234_5679);
    send_seg(FROM_LOCAL, 1'b1, 1'b1, 1'b0, 1'b1, 32'hAAAA_AAAA, 32'h5555_5555);
    send_seg(FROM_PEER,  1'b1, 1'b0, 1'b1, 1'b0, 32'h5555_5555, 32'hAAAA_AAAA);
    wait_drained();

    random_traffic(300);

    // The receiver holds off while headers keep coming, so the input stalls.
    burst        = 1'b1;
    hold_request = 1'b1;
    random_traffic(segments_sent + 25);
    burst = 1'b0;
    wait_drained();

    steady = 1'b1;
    random_traffic(segments_sent + 100);
    steady = 1'b0;

    random_traffic(600);
    wait_drained();
    random_traffic(ITEM_TARGET);

    wait_drained();
    repeat (10) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
